// File: sv/process_scheduler_fifo_rr_sjf_assert.svh
// Assertion macros shared by the scheduler RTL; clock clk, reset arst_n.
`ifndef PROCESS_SCHEDULER_FIFO_RR_SJF_ASSERT_SVH
`define PROCESS_SCHEDULER_FIFO_RR_SJF_ASSERT_SVH

// Same-cycle implication.
`define PSCHED_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PSCHED_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/psched_pkg.sv
// Types and constants for the job-slot scheduler.
`default_nettype none

package psched_pkg;

	localparam int MAX_SLOTS = 32;
	localparam int SLOT_W    = 5;
	localparam int TICK_W    = 24;
	localparam int BURST_W   = 16;
	localparam int CNT_W     = 6;
	localparam int QUANT_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
	localparam logic [CNT_W-1:0]  FIN_MAX  = {CNT_W{1'b1}};

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM   = 2'd2;

	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_RR   = 2'd1,
		POL_SJF  = 2'd2,
		POL_SRTF = 2'd3
	} policy_t;

	typedef struct packed {
		logic                cmd;
		logic [SLOT_W-1:0]   slot;
		logic [TICK_W-1:0]   arrival_tick;
		logic [BURST_W-1:0]  burst_length;
	} sched_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   running_slot;
		logic                cpu_busy;
		logic [SLOT_W-1:0]   finished_slot;
		logic                finished_valid;
		logic                preempted;
		logic                all_done;
		logic [TICK_W-1:0]   tick_now;
	} sched_rsp_t;

	// status of the remainder unit
	typedef struct packed {
		logic done;
		logic zero;
	} urem_stat_t;

endpackage

`default_nettype wire

// File: sv/psched_urem.sv
// Bit-serial remainder unit: tells whether the slice age is a multiple of the quantum.
`default_nettype none

module psched_urem import psched_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [TICK_W-1:0]  dividend,
	input  wire logic [QUANT_W-1:0] divisor,
	output urem_stat_t              stat
);

	localparam int STEP_W = $clog2(TICK_W + 1);

	logic [TICK_W-1:0]  dvd_q;
	logic [QUANT_W-1:0] dsr_q;
	logic [QUANT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	logic [QUANT_W:0]   shifted;
	logic [QUANT_W:0]   diff;
	logic [QUANT_W-1:0] rem_nxt;

	// one restoring step per cycle, MSB first
	assign shifted = {rem_q, dvd_q[TICK_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign rem_nxt = diff[QUANT_W] ? shifted[QUANT_W-1:0] : diff[QUANT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
		end else if (start) begin
			dvd_q  <= dividend;
			dsr_q  <= (divisor == '0) ? QUANT_W'(1) : divisor; // zero acts as one
			rem_q  <= '0;
			step_q <= STEP_W'(TICK_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			dvd_q  <= {dvd_q[TICK_W-2:0], 1'b0};
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

`default_nettype wire

// File: sv/process_scheduler_fifo_rr_sjf.sv
// Top level of the tick-driven job-slot scheduler (FIFO, round robin, SJF, SRTF).
`default_nettype none
`include "process_scheduler_fifo_rr_sjf_assert.svh"

// Job-slot CPU scheduler. Requests on req are either a slot load (cmd 0) or a
// clock tick (cmd 1); every request gives exactly one response on rsp. A load
// writes the slot's arrival tick and burst length into the job table and its
// response is registered at the edge of its transfer. A tick retires the
// running job if it has no time left, marks arrivals, chooses the running job
// by the policy register, charges it one tick and advances the clock. A tick's
// response is registered once the table walk, one slot per cycle over the
// slots in use through its single read port, and the round robin slice check
// in a 24-step serial remainder unit alongside that walk are both done; the
// longer of the two sets the time. A new request is only taken while the
// scheduler is idle and the output register is empty or its response is
// transferred in the same cycle, so with the receiver always ready loads are
// taken every cycle. The job table is not cleared at reset; every slot below
// job_count is read on each tick, loaded or not. Configuration (policy,
// job_count, quantum) is to be written through cfg while no request is in
// flight; the block does not enforce this. cfg_ready is always high. Ties go
// to the lowest slot, but under SRTF the running job keeps the CPU on a tie.

module process_scheduler_fifo_rr_sjf import psched_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire sched_req_t           req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output sched_rsp_t                rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RET,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	// job table: two synchronous memories with registered reads
	logic [TICK_W-1:0]  arr_mem [MAX_SLOTS];
	logic [BURST_W-1:0] rem_mem [MAX_SLOTS];
	logic [TICK_W-1:0]  arr_rd_q;
	logic [BURST_W-1:0] rem_rd_q;
	logic [SLOT_W-1:0]  rd_addr;
	logic [SLOT_W-1:0]  wr_addr;
	logic [BURST_W-1:0] wr_rem;
	logic               we_arr;
	logic               we_rem;

	state_t             state_q;
	policy_t            policy_q;
	logic [CNT_W-1:0]   job_cnt_q;
	logic [QUANT_W-1:0] quantum_q;

	logic [MAX_SLOTS-1:0] arrived_q;
	logic [SLOT_W-1:0]  run_idx_q;
	logic               run_vld_q;
	logic [BURST_W-1:0] run_rem_q;
	logic [TICK_W-1:0]  slice_q;
	logic [TICK_W-1:0]  tick_q;
	logic [CNT_W-1:0]   fin_cnt_q;
	logic               fin_vld_q;
	logic [SLOT_W-1:0]  fin_idx_q;

	// walk over the table: issue counter and the slot whose data is back
	logic [CNT_W-1:0]   scan_idx_q;
	logic               scan_vld_s1;
	logic [SLOT_W-1:0]  scan_idx_s1;

	// candidates gathered during the walk
	logic [CNT_W-1:0]   base_q;
	logic               best_vld_q;
	logic [SLOT_W-1:0]  best_idx_q;
	logic [BURST_W-1:0] best_rem_q;
	logic               lowa_vld_q;
	logic [SLOT_W-1:0]  lowa_idx_q;
	logic [BURST_W-1:0] lowa_rem_q;
	logic               lowb_vld_q;
	logic [SLOT_W-1:0]  lowb_idx_q;
	logic [BURST_W-1:0] lowb_rem_q;

	logic               rsp_valid_q;
	sched_rsp_t         rsp_q;

	logic [CNT_W-1:0]   n_used;
	logic               out_free;
	logic               req_fire;
	logic               load_fire;
	logic               tick_fire;
	logic               load_drop;
	logic               ret_now;
	logic               ret_keep;
	logic               s_new;
	logic               s_rdy;
	logic               commit;

	logic               sw;
	logic               cand_vld;
	logic [SLOT_W-1:0]  cand_idx;
	logic [BURST_W-1:0] cand_rem;
	logic               run_vld_nxt;
	logic [SLOT_W-1:0]  run_idx_nxt;
	logic [BURST_W-1:0] run_rem_nxt;
	logic               pre_nxt;
	logic               take;

	logic [TICK_W-1:0]  slice_age;
	urem_stat_t         urem_stat;

	// slots in use; larger counts act as the table size
	assign n_used = (job_cnt_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : job_cnt_q;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req_valid && req_ready;
	assign load_fire = req_fire && (req.cmd == CMD_LOAD);
	assign tick_fire = req_fire && (req.cmd == CMD_TICK);
	assign load_drop = run_vld_q && (run_idx_q == req.slot);
	assign cfg_ready = 1'b1;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// retirement check on the running slot's remaining time
	assign ret_now  = run_vld_q && (rem_rd_q == '0);
	assign ret_keep = run_vld_q && !ret_now && ({1'b0, run_idx_q} < n_used);

	// arrival and readiness of the slot whose data is back
	assign s_new = !arrived_q[scan_idx_s1] && (arr_rd_q == tick_q);
	assign s_rdy = (arrived_q[scan_idx_s1] || s_new) && (rem_rd_q != '0);

	// slice age for the round robin check
	assign slice_age = tick_q - slice_q;

	psched_urem u_urem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (tick_fire),
		.dividend (slice_age),
		.divisor  (quantum_q),
		.stat     (urem_stat)
	);

	// policy choice once the walk is complete
	always_comb begin
		sw       = 1'b0;
		cand_vld = lowb_vld_q;
		cand_idx = lowb_idx_q;
		cand_rem = lowb_rem_q;
		case (policy_q) inside
			POL_FIFO: begin
				sw = !run_vld_q;
			end
			POL_RR: begin
				sw = !run_vld_q || urem_stat.zero;
				if (lowa_vld_q) begin
					cand_vld = 1'b1;
					cand_idx = lowa_idx_q;
					cand_rem = lowa_rem_q;
				end
			end
			POL_SJF, POL_SRTF: begin
				sw       = (policy_q == POL_SRTF) || !run_vld_q;
				cand_vld = best_vld_q;
				cand_idx = best_idx_q;
				cand_rem = best_rem_q;
			end
			default: begin
				sw = 1'b0;
			end
		endcase

		run_vld_nxt = run_vld_q;
		run_idx_nxt = run_idx_q;
		run_rem_nxt = run_rem_q;
		pre_nxt     = 1'b0;
		take        = 1'b0;
		if (sw) begin
			if (!cand_vld) begin
				run_vld_nxt = 1'b0;
			end else if (!run_vld_q || cand_idx != run_idx_q) begin
				pre_nxt     = run_vld_q;
				run_vld_nxt = 1'b1;
				run_idx_nxt = cand_idx;
				run_rem_nxt = cand_rem;
				take        = 1'b1;
			end
		end
	end

	assign commit = (state_q == ST_DECIDE) && urem_stat.done && out_free;

	// table ports
	always_comb begin
		unique case (state_q)
			ST_IDLE:   rd_addr = run_idx_q;
			ST_RET:    rd_addr = '0;
			ST_SCAN:   rd_addr = scan_idx_q[SLOT_W-1:0];
			ST_DECIDE: rd_addr = run_idx_q;
			default:   rd_addr = run_idx_q;
		endcase
	end

	assign we_arr  = load_fire;
	assign we_rem  = load_fire || (commit && run_vld_nxt);
	assign wr_addr = load_fire ? req.slot : run_idx_nxt;
	// the running job always has time left, so the charge cannot wrap
	assign wr_rem  = load_fire ? req.burst_length : (run_rem_nxt - 1'b1);

	always_ff @(posedge clk) begin
		if (we_arr)
			arr_mem[wr_addr] <= req.arrival_tick;
		if (we_rem)
			rem_mem[wr_addr] <= wr_rem;
		arr_rd_q <= arr_mem[rd_addr];
		rem_rd_q <= rem_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= POL_FIFO;
			job_cnt_q   <= CNT_W'(1);
			quantum_q   <= QUANT_W'(500);
			arrived_q   <= '0;
			run_idx_q   <= '0;
			run_vld_q   <= 1'b0;
			run_rem_q   <= '0;
			slice_q     <= '0;
			tick_q      <= '0;
			fin_cnt_q   <= '0;
			fin_vld_q   <= 1'b0;
			fin_idx_q   <= '0;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
			scan_idx_s1 <= '0;
			base_q      <= '0;
			best_vld_q  <= 1'b0;
			best_idx_q  <= '0;
			best_rem_q  <= '0;
			lowa_vld_q  <= 1'b0;
			lowa_idx_q  <= '0;
			lowa_rem_q  <= '0;
			lowb_vld_q  <= 1'b0;
			lowb_idx_q  <= '0;
			lowb_rem_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// a new response in the same cycle keeps the register full
			if (rsp_valid_q && rsp_ready && !load_fire && !commit)
				rsp_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_POLICY:    policy_q  <= policy_t'(cfg_data[1:0]);
					REG_JOB_COUNT: job_cnt_q <= cfg_data[CNT_W-1:0];
					REG_QUANTUM:   quantum_q <= cfg_data[QUANT_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (load_fire) begin
						arrived_q[req.slot] <= 1'b0;
						if (load_drop)
							run_vld_q <= 1'b0;
						rsp_q.running_slot   <= (run_vld_q && !load_drop) ? run_idx_q : '0;
						rsp_q.cpu_busy       <= run_vld_q && !load_drop;
						rsp_q.finished_slot  <= '0;
						rsp_q.finished_valid <= 1'b0;
						rsp_q.preempted      <= 1'b0;
						rsp_q.all_done       <= (fin_cnt_q >= n_used);
						rsp_q.tick_now       <= tick_q;
						rsp_valid_q          <= 1'b1;
					end else if (tick_fire) begin
						state_q <= ST_RET;
					end
				end

				ST_RET: begin
					// running slot's remaining time is back
					fin_vld_q <= ret_now;
					fin_idx_q <= run_idx_q;
					if (ret_now && fin_cnt_q != FIN_MAX)
						fin_cnt_q <= fin_cnt_q + 1'b1;
					run_vld_q  <= ret_keep;
					run_rem_q  <= rem_rd_q;
					best_vld_q <= (policy_q == POL_SRTF) && ret_keep;
					best_idx_q <= run_idx_q;
					best_rem_q <= rem_rd_q;
					base_q     <= ret_keep ? ({1'b0, run_idx_q} + 1'b1) : '0;
					lowa_vld_q <= 1'b0;
					lowb_vld_q <= 1'b0;
					// slot 0 was addressed this cycle
					scan_vld_s1 <= (n_used != '0);
					scan_idx_s1 <= '0;
					scan_idx_q  <= CNT_W'(1);
					state_q     <= ST_SCAN;
				end

				ST_SCAN: begin
					if (scan_vld_s1) begin
						if (s_new) begin
							arrived_q[scan_idx_s1] <= 1'b1;
							// zero-length job retires on arrival
							if (rem_rd_q == '0 && fin_cnt_q != FIN_MAX)
								fin_cnt_q <= fin_cnt_q + 1'b1;
						end
						if (s_rdy) begin
							if (!lowb_vld_q) begin
								lowb_vld_q <= 1'b1;
								lowb_idx_q <= scan_idx_s1;
								lowb_rem_q <= rem_rd_q;
							end
							if (!lowa_vld_q && ({1'b0, scan_idx_s1} >= base_q)) begin
								lowa_vld_q <= 1'b1;
								lowa_idx_q <= scan_idx_s1;
								lowa_rem_q <= rem_rd_q;
							end
							if (!best_vld_q || rem_rd_q < best_rem_q) begin
								best_vld_q <= 1'b1;
								best_idx_q <= scan_idx_s1;
								best_rem_q <= rem_rd_q;
							end
						end
					end
					scan_vld_s1 <= (scan_idx_q < n_used);
					scan_idx_s1 <= scan_idx_q[SLOT_W-1:0];
					if (scan_idx_q < n_used)
						scan_idx_q <= scan_idx_q + 1'b1;
					else
						state_q <= ST_DECIDE;
				end

				ST_DECIDE: begin
					if (commit) begin
						run_vld_q <= run_vld_nxt;
						run_idx_q <= run_idx_nxt;
						if (take)
							slice_q <= tick_q;
						rsp_q.running_slot   <= run_vld_nxt ? run_idx_nxt : '0;
						rsp_q.cpu_busy       <= run_vld_nxt;
						rsp_q.finished_slot  <= fin_vld_q ? fin_idx_q : '0;
						rsp_q.finished_valid <= fin_vld_q;
						rsp_q.preempted      <= pre_nxt;
						rsp_q.all_done       <= (fin_cnt_q >= n_used);
						rsp_q.tick_now       <= tick_q;
						rsp_valid_q          <= 1'b1;
						if (tick_q != TICK_MAX)
							tick_q <= tick_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a retired slot has no time left, so it cannot be picked in the same tick
	`PSCHED_ASSERT_IMP(a_fin_not_run, rsp_valid_q && rsp_q.finished_valid && rsp_q.cpu_busy, rsp_q.running_slot != rsp_q.finished_slot, "retired slot reported as running")
	// a displacement always leaves some job on the CPU
	`PSCHED_ASSERT_IMP(a_pre_busy, rsp_valid_q && rsp_q.preempted, rsp_q.cpu_busy, "preemption with idle CPU")
	// a load leaves its slot not yet arrived
	`PSCHED_ASSERT_NXT(a_load_clears, load_fire, !arrived_q[$past(req.slot)], "arrived flag not cleared by load")
	// the choice waits for the slice check
	`PSCHED_ASSERT_NXT(a_decide_wait, state_q == ST_DECIDE && !urem_stat.done, state_q == ST_DECIDE, "choice made before remainder unit finished")

endmodule

`default_nettype wire
